/* src/wbc_pkg.sv */
// ----------------------------------------------------------------------------
// wbc_pkg
// shared types and constants of the weighting biquad cascade: request and
// result structs, command and coefficient slot codes, datapath widths
// ----------------------------------------------------------------------------
package wbc_pkg;

	localparam int SECTIONS    = 5;
	localparam int SAMPLE_BITS = 24;
	localparam int COEF_BITS   = 32;
	localparam int COEF_SLOTS  = 5;
	localparam int COEF_FRAC   = COEF_BITS - 4;
	localparam int DELAY_BITS  = SAMPLE_BITS + 24;
	localparam int DELAY_FRAC  = 20;
	localparam int ALIGN_SHIFT = COEF_FRAC - DELAY_FRAC;

	localparam int PROD_W      = COEF_BITS + SAMPLE_BITS;
	localparam int ACC_W       = PROD_W + 4;
	localparam int SEC_W       = $clog2(SECTIONS + 1);
	localparam int SEC_IDX_W   = $clog2(SECTIONS);
	localparam int COEF_DEPTH  = SECTIONS * COEF_SLOTS;
	localparam int COEF_IDX_W  = $clog2(COEF_DEPTH + 1);

	localparam logic [1:0] CMD_FILTER = 2'd0;
	localparam logic [1:0] CMD_WRITE  = 2'd1;
	localparam logic [1:0] CMD_CLEAR  = 2'd2;

	localparam logic [2:0] SLOT_B0 = 3'd0;
	localparam logic [2:0] SLOT_B1 = 3'd1;
	localparam logic [2:0] SLOT_B2 = 3'd2;
	localparam logic [2:0] SLOT_A1 = 3'd3;
	localparam logic [2:0] SLOT_A2 = 3'd4;

	localparam logic signed [ACC_W-1:0] ROUND_ALIGN = ACC_W'(1) <<< (ALIGN_SHIFT - 1);
	localparam logic signed [ACC_W-1:0] ROUND_FRAC  = ACC_W'(1) <<< (DELAY_FRAC - 1);

	localparam logic signed [ACC_W-1:0] SAMPLE_MAX =
		{{(ACC_W - SAMPLE_BITS + 1){1'b0}}, {(SAMPLE_BITS - 1){1'b1}}};
	localparam logic signed [ACC_W-1:0] SAMPLE_MIN =
		{{(ACC_W - SAMPLE_BITS + 1){1'b1}}, {(SAMPLE_BITS - 1){1'b0}}};
	localparam logic signed [ACC_W-1:0] DELAY_MAX =
		{{(ACC_W - DELAY_BITS + 1){1'b0}}, {(DELAY_BITS - 1){1'b1}}};
	localparam logic signed [ACC_W-1:0] DELAY_MIN =
		{{(ACC_W - DELAY_BITS + 1){1'b1}}, {(DELAY_BITS - 1){1'b0}}};

	typedef struct packed {
		logic [1:0]                    command;
		logic signed [SAMPLE_BITS-1:0] sample_in;
		logic [2:0]                    section_index;
		logic [2:0]                    coef_index;
		logic signed [COEF_BITS-1:0]   coef_value;
	} in_item_t;

	typedef struct packed {
		logic signed [SAMPLE_BITS-1:0] sample_out;
		logic                          overflow;
	} out_item_t;

endpackage

/* src/weighting_biquad_cascade.sv */
// ----------------------------------------------------------------------------
// weighting_biquad_cascade
// cascade of second-order iir sections in transposed direct form, computed
// on one shared multiplier and adder under a small sequencer
// ----------------------------------------------------------------------------
//  channel   direction  handshake            payload
//  in        input      in_valid/in_ready    wbc_pkg::in_item_t
//  out       output     out_valid/out_ready  wbc_pkg::out_item_t
//  cfg       input      cfg_we               cfg_wdata (section enable)
//
//  a filter request makes one sequencer visit per section and runs the
//  multiply/add steps of each enabled section on the single multiplier;
//  write, clear and unused requests complete on accept and leave the
//  sequencer idle. in_ready is high only while the sequencer idles.
//  a result waits in the output register; a stalled output holds the
//  sequencer in its final step. reset clears coefficients, delay words and
//  the enable register.
// ----------------------------------------------------------------------------
module weighting_biquad_cascade (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  wbc_pkg::in_item_t   in_data,
	output logic                out_valid,
	input  logic                out_ready,
	output wbc_pkg::out_item_t  out_data,
	input  logic                cfg_we,
	input  logic [wbc_pkg::SECTIONS-1:0] cfg_wdata
);

	typedef enum logic [12:0] {
		ST_IDLE = 13'b0000000000001,
		ST_SEL  = 13'b0000000000010,
		ST_RD0  = 13'b0000000000100,
		ST_MB0  = 13'b0000000001000,
		ST_ACC  = 13'b0000000010000,
		ST_YO   = 13'b0000000100000,
		ST_MA1  = 13'b0000001000000,
		ST_N1   = 13'b0000010000000,
		ST_W1   = 13'b0000100000000,
		ST_MA2  = 13'b0001000000000,
		ST_N2   = 13'b0010000000000,
		ST_W2   = 13'b0100000000000,
		ST_DONE = 13'b1000000000000
	} state_t;

	state_t                                    state_q;
	logic [wbc_pkg::SECTIONS-1:0]              en_q;
	logic [wbc_pkg::SEC_W-1:0]                 sec_q;
	logic [wbc_pkg::COEF_IDX_W-1:0]            base_q;
	logic signed [wbc_pkg::SAMPLE_BITS-1:0]    x_q;
	logic signed [wbc_pkg::SAMPLE_BITS-1:0]    y_q;
	logic                                      ov_q;
	logic signed [wbc_pkg::COEF_BITS-1:0]      coef_q;
	logic signed [wbc_pkg::PROD_W-1:0]         prod_q;
	logic signed [wbc_pkg::PROD_W-1:0]         sum_q;
	logic signed [wbc_pkg::ACC_W-1:0]          acc_q;
	logic                                      out_valid_q;
	wbc_pkg::out_item_t                        out_q;

	logic signed [wbc_pkg::COEF_BITS-1:0]      coef_mem_q [wbc_pkg::COEF_DEPTH];
	logic signed [wbc_pkg::DELAY_BITS-1:0]     s1_q [wbc_pkg::SECTIONS];
	logic signed [wbc_pkg::DELAY_BITS-1:0]     s2_q [wbc_pkg::SECTIONS];

	logic                                      accept;
	logic                                      out_free;
	logic [wbc_pkg::SEC_IDX_W-1:0]             sec_idx;
	logic [wbc_pkg::COEF_IDX_W-1:0]            wr_idx;
	logic                                      wr_ok;
	logic [2:0]                                rd_slot;
	logic [wbc_pkg::COEF_IDX_W-1:0]            rd_idx;
	logic signed [wbc_pkg::SAMPLE_BITS-1:0]    mul_b;
	logic signed [wbc_pkg::PROD_W-1:0]         mul_res;
	logic signed [wbc_pkg::ACC_W-1:0]          add_a;
	logic signed [wbc_pkg::ACC_W-1:0]          add_r;
	logic signed [wbc_pkg::ACC_W-1:0]          add_s;
	logic signed [wbc_pkg::ACC_W-1:0]          add_sum;
	logic signed [wbc_pkg::ACC_W-1:0]          add_shr;
	logic                                      sat_hi;
	logic                                      sat_lo;
	logic signed [wbc_pkg::SAMPLE_BITS-1:0]    y_sat;
	logic signed [wbc_pkg::DELAY_BITS-1:0]     d_sat;

	assign in_ready  = (state_q == ST_IDLE);
	assign accept    = in_valid && in_ready;
	assign out_free  = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;
	assign sec_idx   = sec_q[wbc_pkg::SEC_IDX_W-1:0];

	assign wr_idx = wbc_pkg::COEF_IDX_W'(in_data.section_index)
		* wbc_pkg::COEF_IDX_W'(wbc_pkg::COEF_SLOTS)
		+ wbc_pkg::COEF_IDX_W'(in_data.coef_index);
	assign wr_ok  = (32'(in_data.section_index) < wbc_pkg::SECTIONS)
		&& (32'(in_data.coef_index) < wbc_pkg::COEF_SLOTS);

	// coefficient slot fetched ahead of each multiply
	always_comb begin
		case (state_q)
			ST_RD0:  rd_slot = wbc_pkg::SLOT_B0;
			ST_MB0:  rd_slot = wbc_pkg::SLOT_B1;
			ST_YO:   rd_slot = wbc_pkg::SLOT_A1;
			ST_MA1:  rd_slot = wbc_pkg::SLOT_B2;
			default: rd_slot = wbc_pkg::SLOT_A2;
		endcase
	end
	assign rd_idx = base_q + wbc_pkg::COEF_IDX_W'(rd_slot);

	// shared multiplier
	assign mul_b   = (state_q == ST_MA1 || state_q == ST_MA2) ? y_q : x_q;
	assign mul_res = wbc_pkg::PROD_W'(coef_q) * wbc_pkg::PROD_W'(mul_b);

	// shared rounding adder
	always_comb begin
		add_a = acc_q;
		add_r = wbc_pkg::ROUND_ALIGN;
		add_s = '0;
		case (state_q)
			ST_ACC: begin
				add_a = wbc_pkg::ACC_W'(prod_q);
				add_s = wbc_pkg::ACC_W'(s1_q[sec_idx]) <<< wbc_pkg::ALIGN_SHIFT;
			end
			ST_YO: begin
				add_r = wbc_pkg::ROUND_FRAC;
			end
			ST_W1: begin
				add_s = wbc_pkg::ACC_W'(s2_q[sec_idx]) <<< wbc_pkg::ALIGN_SHIFT;
			end
			default: begin
			end
		endcase
		add_sum = add_a + add_r + add_s;
		add_shr = (state_q == ST_YO) ? (add_sum >>> wbc_pkg::DELAY_FRAC)
			: (add_sum >>> wbc_pkg::ALIGN_SHIFT);
	end

	// saturation to sample or delay word range
	always_comb begin
		if (state_q == ST_YO) begin
			sat_hi = add_shr > wbc_pkg::SAMPLE_MAX;
			sat_lo = add_shr < wbc_pkg::SAMPLE_MIN;
		end else begin
			sat_hi = add_shr > wbc_pkg::DELAY_MAX;
			sat_lo = add_shr < wbc_pkg::DELAY_MIN;
		end
		if (sat_hi) begin
			y_sat = wbc_pkg::SAMPLE_MAX[wbc_pkg::SAMPLE_BITS-1:0];
			d_sat = wbc_pkg::DELAY_MAX[wbc_pkg::DELAY_BITS-1:0];
		end else if (sat_lo) begin
			y_sat = wbc_pkg::SAMPLE_MIN[wbc_pkg::SAMPLE_BITS-1:0];
			d_sat = wbc_pkg::DELAY_MIN[wbc_pkg::DELAY_BITS-1:0];
		end else begin
			y_sat = add_shr[wbc_pkg::SAMPLE_BITS-1:0];
			d_sat = add_shr[wbc_pkg::DELAY_BITS-1:0];
		end
	end

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			en_q <= '0;
		end else if (cfg_we) begin
			en_q <= cfg_wdata;
		end
	end

	// coefficient store
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < wbc_pkg::COEF_DEPTH; i++) begin
				coef_mem_q[i] <= '0;
			end
		end else if (accept && in_data.command == wbc_pkg::CMD_WRITE && wr_ok) begin
			coef_mem_q[wr_idx] <= in_data.coef_value;
		end
	end

	// delay store
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < wbc_pkg::SECTIONS; i++) begin
				s1_q[i] <= '0;
				s2_q[i] <= '0;
			end
		end else if (accept && in_data.command == wbc_pkg::CMD_CLEAR) begin
			for (int i = 0; i < wbc_pkg::SECTIONS; i++) begin
				s1_q[i] <= '0;
				s2_q[i] <= '0;
			end
		end else if (state_q == ST_W1) begin
			s1_q[sec_idx] <= d_sat;
		end else if (state_q == ST_W2) begin
			s2_q[sec_idx] <= d_sat;
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		coef_q <= coef_mem_q[rd_idx];
		case (state_q)
			ST_MB0, ST_ACC, ST_MA1, ST_N1, ST_MA2: prod_q <= mul_res;
			default: begin
			end
		endcase
		case (state_q)
			ST_ACC: acc_q <= add_shr;
			ST_N1, ST_N2: acc_q <= wbc_pkg::ACC_W'(sum_q) - wbc_pkg::ACC_W'(prod_q);
			default: begin
			end
		endcase
		if (state_q == ST_YO || state_q == ST_W1) begin
			sum_q <= prod_q;
		end
		if (state_q == ST_YO) begin
			y_q <= y_sat;
		end
		if (accept) begin
			x_q <= in_data.sample_in;
		end else if (state_q == ST_W2) begin
			x_q <= y_q;
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			sec_q       <= '0;
			base_q      <= '0;
			ov_q        <= 1'b0;
			out_valid_q <= 1'b0;
			out_q       <= '0;
		end else begin
			if (state_q == ST_DONE && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept && in_data.command == wbc_pkg::CMD_FILTER) begin
						sec_q   <= '0;
						base_q  <= '0;
						ov_q    <= 1'b0;
						state_q <= ST_SEL;
					end
				end
				ST_SEL: begin
					if (32'(sec_q) >= wbc_pkg::SECTIONS) begin
						state_q <= ST_DONE;
					end else if (en_q[sec_idx]) begin
						state_q <= ST_RD0;
					end else begin
						sec_q  <= sec_q + 1'b1;
						base_q <= base_q + wbc_pkg::COEF_IDX_W'(wbc_pkg::COEF_SLOTS);
					end
				end
				ST_RD0: state_q <= ST_MB0;
				ST_MB0: state_q <= ST_ACC;
				ST_ACC: state_q <= ST_YO;
				ST_YO: begin
					if (sat_hi || sat_lo) begin
						ov_q <= 1'b1;
					end
					state_q <= ST_MA1;
				end
				ST_MA1: state_q <= ST_N1;
				ST_N1:  state_q <= ST_W1;
				ST_W1: begin
					if (sat_hi || sat_lo) begin
						ov_q <= 1'b1;
					end
					state_q <= ST_MA2;
				end
				ST_MA2: state_q <= ST_N2;
				ST_N2:  state_q <= ST_W2;
				ST_W2: begin
					if (sat_hi || sat_lo) begin
						ov_q <= 1'b1;
					end
					sec_q   <= sec_q + 1'b1;
					base_q  <= base_q + wbc_pkg::COEF_IDX_W'(wbc_pkg::COEF_SLOTS);
					state_q <= ST_SEL;
				end
				ST_DONE: begin
					if (out_free) begin
						out_q.sample_out <= x_q;
						out_q.overflow   <= ov_q;
						state_q          <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	a_state_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot(state_q))
		else $error("sequencer state not one-hot");

	a_sec_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE && state_q != ST_SEL && state_q != ST_DONE)
		|-> (32'(sec_q) < wbc_pkg::SECTIONS))
		else $error("section counter out of range during section steps");

	a_base_track: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |-> (base_q == wbc_pkg::COEF_IDX_W'(
			wbc_pkg::COEF_IDX_W'(sec_q) * wbc_pkg::COEF_IDX_W'(wbc_pkg::COEF_SLOTS))))
		else $error("coefficient base out of step with section counter");

	a_done_delivers: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DONE && out_free) |=> (out_valid_q && state_q == ST_IDLE))
		else $error("finished request not delivered to output register");

endmodule

/* dv/tb_weighting_biquad_cascade.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_weighting_biquad_cascade
// self-checking bench for the weighting biquad cascade. a queue of pending
// requests feeds a valid/ready driver; every accepted request also runs
// through a fixed-point cascade predictor held here. a monitor takes
// results under random back-pressure and compares them field by field with
// the predicted ones. directed corner requests come first, then phases that
// load stable coefficient sets under different section enables, followed
// by random filter, write, clear and unused requests.
// ----------------------------------------------------------------------------
module tb_weighting_biquad_cascade;

	localparam int LIMIT_CYCLES   = 500000;
	localparam int SETTLE_CYCLES  = 8 + 10 * wbc_pkg::SECTIONS + 12;
	localparam int HOLD_CYCLES    = 500;
	localparam int RANDOM_PHASES  = 8;
	localparam int PHASE_REQUESTS = 80;

	localparam logic [1:0] CMD_UNUSED = 2'd3;

	localparam logic signed [wbc_pkg::COEF_BITS-1:0] Q_ONE =
		wbc_pkg::COEF_BITS'(1) << wbc_pkg::COEF_FRAC;
	localparam logic signed [wbc_pkg::COEF_BITS-1:0] Q_MAX =
		{1'b0, {(wbc_pkg::COEF_BITS-1){1'b1}}};
	localparam logic signed [wbc_pkg::COEF_BITS-1:0] Q_MIN =
		{1'b1, {(wbc_pkg::COEF_BITS-1){1'b0}}};
	localparam logic signed [wbc_pkg::SAMPLE_BITS-1:0] S_MAX =
		{1'b0, {(wbc_pkg::SAMPLE_BITS-1){1'b1}}};
	localparam logic signed [wbc_pkg::SAMPLE_BITS-1:0] S_MIN =
		{1'b1, {(wbc_pkg::SAMPLE_BITS-1){1'b0}}};

	logic                         clk       = 1'b0;
	logic                         arst_n    = 1'b0;
	logic                         in_valid  = 1'b0;
	logic                         in_ready;
	wbc_pkg::in_item_t            in_data   = '0;
	logic                         out_valid;
	logic                         out_ready = 1'b0;
	wbc_pkg::out_item_t           out_data;
	logic                         cfg_we    = 1'b0;
	logic [wbc_pkg::SECTIONS-1:0] cfg_wdata = '0;

	wbc_pkg::in_item_t            request_queue[$];
	wbc_pkg::out_item_t           predicted_out[$];
	longint                       coef_copy[wbc_pkg::COEF_DEPTH];
	longint                       delay_copy[2*wbc_pkg::SECTIONS];
	logic [wbc_pkg::SECTIONS-1:0] enable_copy = '0;

	int idle_odds   = 0;
	int send_gap    = 0;
	int recv_gap    = 0;
	int hold_left   = 0;
	bit hold_arm    = 1'b0;
	bit hold_done   = 1'b0;
	int mismatches  = 0;
	int cycle_count = 0;

	weighting_biquad_cascade dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	always #6 clk = ~clk;

	// multiply by 2^-s, rounding half up
	function automatic longint round_shift(longint v, int s);
		return (v + (64'sd1 <<< (s - 1))) >>> s;
	endfunction

	function automatic longint clamp(longint v, int w, inout bit ov);
		longint hi;
		longint lo;
		hi = (64'sd1 <<< (w - 1)) - 1;
		lo = -hi - 1;
		if (v > hi) begin
			ov = 1'b1;
			return hi;
		end
		if (v < lo) begin
			ov = 1'b1;
			return lo;
		end
		return v;
	endfunction

	function automatic wbc_pkg::out_item_t weigh_sample(
		logic signed [wbc_pkg::SAMPLE_BITS-1:0] s);
		wbc_pkg::out_item_t r;
		longint             x;
		longint             acc;
		longint             y;
		longint             n1;
		longint             n2;
		bit                 ov;
		int                 b;
		x  = longint'($signed(s));
		ov = 1'b0;
		for (int k = 0; k < wbc_pkg::SECTIONS; k++) begin
			if (enable_copy[k]) begin
				b   = k * wbc_pkg::COEF_SLOTS;
				acc = round_shift(coef_copy[b+wbc_pkg::SLOT_B0] * x, wbc_pkg::ALIGN_SHIFT)
					+ delay_copy[2*k];
				y   = clamp(round_shift(acc, wbc_pkg::DELAY_FRAC), wbc_pkg::SAMPLE_BITS, ov);
				n1  = round_shift(coef_copy[b+wbc_pkg::SLOT_B1] * x
					- coef_copy[b+wbc_pkg::SLOT_A1] * y, wbc_pkg::ALIGN_SHIFT)
					+ delay_copy[2*k+1];
				n2  = round_shift(coef_copy[b+wbc_pkg::SLOT_B2] * x
					- coef_copy[b+wbc_pkg::SLOT_A2] * y, wbc_pkg::ALIGN_SHIFT);
				delay_copy[2*k]   = clamp(n1, wbc_pkg::DELAY_BITS, ov);
				delay_copy[2*k+1] = clamp(n2, wbc_pkg::DELAY_BITS, ov);
				x = y;
			end
		end
		r.sample_out = wbc_pkg::SAMPLE_BITS'(x);
		r.overflow   = ov;
		return r;
	endfunction

	function automatic void model_request(wbc_pkg::in_item_t r);
		case (r.command)
			wbc_pkg::CMD_FILTER: predicted_out.push_back(weigh_sample(r.sample_in));
			wbc_pkg::CMD_WRITE: begin
				if (r.section_index < wbc_pkg::SECTIONS
					&& r.coef_index < wbc_pkg::COEF_SLOTS)
					coef_copy[r.section_index * wbc_pkg::COEF_SLOTS + r.coef_index] =
						longint'($signed(r.coef_value));
			end
			wbc_pkg::CMD_CLEAR: begin
				foreach (delay_copy[i])
					delay_copy[i] = 0;
			end
			default: ;
		endcase
	endfunction

	function automatic int rand_milli(int m);
		return int'($urandom_range(0, 2 * m)) - m;
	endfunction

	function automatic logic signed [wbc_pkg::COEF_BITS-1:0] q_milli(int m);
		return wbc_pkg::COEF_BITS'((longint'(m) <<< wbc_pkg::COEF_FRAC) / 1000);
	endfunction

	function automatic wbc_pkg::in_item_t filter_req(
		logic signed [wbc_pkg::SAMPLE_BITS-1:0] s);
		wbc_pkg::in_item_t r;
		r           = '0;
		r.command   = wbc_pkg::CMD_FILTER;
		r.sample_in = s;
		return r;
	endfunction

	function automatic wbc_pkg::in_item_t coef_req(int sec, logic [2:0] slot,
		logic signed [wbc_pkg::COEF_BITS-1:0] v);
		wbc_pkg::in_item_t r;
		r               = '0;
		r.command       = wbc_pkg::CMD_WRITE;
		r.section_index = 3'(sec);
		r.coef_index    = slot;
		r.coef_value    = v;
		return r;
	endfunction

	function automatic wbc_pkg::in_item_t cmd_req(logic [1:0] c);
		wbc_pkg::in_item_t r;
		r         = '0;
		r.command = c;
		return r;
	endfunction

	function automatic wbc_pkg::in_item_t random_request();
		wbc_pkg::in_item_t r;
		int                pick;
		r.command       = wbc_pkg::CMD_FILTER;
		r.sample_in     = wbc_pkg::SAMPLE_BITS'($urandom);
		r.section_index = 3'($urandom);
		r.coef_index    = 3'($urandom);
		r.coef_value    = wbc_pkg::COEF_BITS'($urandom);
		pick = $urandom_range(0, 99);
		if (pick < 84) begin
			case ($urandom_range(0, 2))
				0: r.sample_in = wbc_pkg::SAMPLE_BITS'(rand_milli(2000));
				1: r.sample_in = wbc_pkg::SAMPLE_BITS'(rand_milli(1 << 20));
				default: ;
			endcase
		end else if (pick < 93) begin
			r.command = wbc_pkg::CMD_WRITE;
			if (pick < 90) begin
				r.section_index = 3'($urandom_range(0, wbc_pkg::SECTIONS - 1));
				r.coef_index    = 3'($urandom_range(0, wbc_pkg::COEF_SLOTS - 1));
				r.coef_value    = q_milli(rand_milli(900));
			end
		end else if (pick < 97) begin
			r.command = wbc_pkg::CMD_CLEAR;
		end else begin
			r.command = CMD_UNUSED;
		end
		return r;
	endfunction

	// stable sections, some of them first order
	task automatic load_cascade();
		int a2m;
		int lim;
		bit first_order;
		for (int s = 0; s < wbc_pkg::SECTIONS; s++) begin
			first_order = ($urandom_range(0, 3) == 0);
			a2m = first_order ? 0 : int'($urandom_range(0, 1700)) - 800;
			lim = (1000 + a2m) * 95 / 100;
			request_queue.push_back(coef_req(s, wbc_pkg::SLOT_B0,
				q_milli(rand_milli(1000))));
			request_queue.push_back(coef_req(s, wbc_pkg::SLOT_B1,
				q_milli(rand_milli(1000))));
			request_queue.push_back(coef_req(s, wbc_pkg::SLOT_B2,
				first_order ? '0 : q_milli(rand_milli(1000))));
			request_queue.push_back(coef_req(s, wbc_pkg::SLOT_A1,
				q_milli(rand_milli(lim))));
			request_queue.push_back(coef_req(s, wbc_pkg::SLOT_A2, q_milli(a2m)));
		end
	endtask

	task automatic set_enable(logic [wbc_pkg::SECTIONS-1:0] v);
		@(posedge clk);
		cfg_we      <= 1'b1;
		cfg_wdata   <= v;
		enable_copy  = v;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	task automatic wait_idle();
		while (request_queue.size() != 0 || in_valid || predicted_out.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic note_mismatch(string what, longint want, longint got);
		mismatches++;
		if (mismatches <= 10)
			$display("mismatch %s: expected %0d got %0d", what, want, got);
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			in_data  <= '0;
			send_gap  = 0;
		end else begin
			if (in_valid && in_ready) begin
				model_request(in_data);
				if (idle_odds != 0 && $urandom_range(1, idle_odds) == 1)
					send_gap = $urandom_range(1, 12);
			end
			if (!in_valid || in_ready) begin
				if (send_gap != 0) begin
					send_gap--;
					in_valid <= 1'b0;
				end else if (request_queue.size() != 0) begin
					in_valid <= 1'b1;
					in_data  <= request_queue.pop_front();
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin : result_check
		wbc_pkg::out_item_t want;
		if (!arst_n) begin
			out_ready <= 1'b0;
			recv_gap   = 0;
		end else begin
			if (out_valid && out_ready) begin
				if (predicted_out.size() == 0) begin
					note_mismatch("unexpected result, sample_out", 0, out_data.sample_out);
				end else begin
					want = predicted_out.pop_front();
					if (out_data.sample_out !== want.sample_out)
						note_mismatch("sample_out", want.sample_out, out_data.sample_out);
					if (out_data.overflow !== want.overflow)
						note_mismatch("overflow", want.overflow, out_data.overflow);
				end
			end
			if (recv_gap != 0) begin
				recv_gap--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= (hold_left == 0);
				if (idle_odds != 0 && $urandom_range(1, 3 * idle_odds) == 1)
					recv_gap = $urandom_range(1, 12);
			end
		end
	end

	// long receiver hold-off so the cascade backs up into its input
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_left <= 0;
			hold_done <= 1'b0;
		end else if (hold_arm && !hold_done) begin
			hold_left <= HOLD_CYCLES;
			hold_done <= 1'b1;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= LIMIT_CYCLES) begin
			$display("tb_weighting_biquad_cascade: errors");
			$finish;
		end
	end

	initial begin
		logic [wbc_pkg::SECTIONS-1:0] en;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// all sections bypassed
		request_queue.push_back(filter_req('0));
		request_queue.push_back(filter_req(S_MAX));
		request_queue.push_back(filter_req(S_MIN));
		request_queue.push_back(filter_req(-24'sd1));
		request_queue.push_back(cmd_req(CMD_UNUSED));
		request_queue.push_back(coef_req(7, wbc_pkg::SLOT_B0, Q_ONE));
		request_queue.push_back(coef_req(0, 3'd7, Q_ONE));
		request_queue.push_back(cmd_req(wbc_pkg::CMD_CLEAR));
		request_queue.push_back(filter_req(24'sd5));
		wait_idle();

		// unwritten coefficients
		set_enable('1);
		request_queue.push_back(filter_req(S_MAX));
		wait_idle();

		// coefficient extremes and saturation in section 0
		set_enable(wbc_pkg::SECTIONS'(1));
		request_queue.push_back(coef_req(0, wbc_pkg::SLOT_B0, Q_MAX));
		request_queue.push_back(filter_req(S_MAX));
		request_queue.push_back(filter_req(S_MIN));
		request_queue.push_back(coef_req(0, wbc_pkg::SLOT_B0, Q_MIN));
		request_queue.push_back(filter_req(S_MAX));
		request_queue.push_back(filter_req(S_MIN));
		request_queue.push_back(coef_req(0, wbc_pkg::SLOT_B0, Q_ONE));
		request_queue.push_back(coef_req(0, wbc_pkg::SLOT_B1, Q_MAX));
		request_queue.push_back(coef_req(0, wbc_pkg::SLOT_A1, Q_MIN));
		request_queue.push_back(coef_req(0, wbc_pkg::SLOT_A2, Q_MIN));
		request_queue.push_back(filter_req(S_MAX));
		request_queue.push_back(filter_req('0));
		request_queue.push_back(filter_req(S_MIN));
		request_queue.push_back(cmd_req(wbc_pkg::CMD_CLEAR));
		request_queue.push_back(filter_req(24'sd100));
		wait_idle();

		for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
			if (ph == RANDOM_PHASES - 1)
				idle_odds = 0;
			else
				idle_odds = (ph % 3 == 0) ? 4 : ((ph % 3 == 1) ? 12 : 40);
			if (ph == 0 || ph == RANDOM_PHASES - 1)
				en = '1;
			else if (ph == 3)
				en = '0;
			else
				en = wbc_pkg::SECTIONS'($urandom_range(1, (1 << wbc_pkg::SECTIONS) - 2));
			set_enable(en);
			if (ph == 1)
				hold_arm = 1'b1;
			load_cascade();
			request_queue.push_back(cmd_req(wbc_pkg::CMD_CLEAR));
			repeat (PHASE_REQUESTS) request_queue.push_back(random_request());
			wait_idle();
		end

		if (mismatches == 0 && predicted_out.size() == 0)
			$display("tb_weighting_biquad_cascade: clean");
		else
			$display("tb_weighting_biquad_cascade: errors");
		$finish;
	end

endmodule
